// ===== rtl/core/itra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra_pkg
// shared types and constants for the radix to ascii converter
// ----------------------------------------------------------------------------
package itra_pkg;

	localparam int RADIX_BITS = 5;
	localparam int CHAR_BITS  = 8;

	localparam logic [RADIX_BITS-1:0] RADIX_BIN   = 5'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 5'd8;
	localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 5'd10;
	localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 5'd16;
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_DEC;

	localparam logic [CHAR_BITS-1:0] ERR_CHAR = 8'h00;

	localparam logic [CHAR_BITS-1:0] DIGIT_TABLE [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	typedef enum logic [1:0] {
		RSEL_BIN,
		RSEL_OCT,
		RSEL_DEC,
		RSEL_HEX
	} radix_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/itra_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra interfaces
// request channels for value in, characters out and radix writes
// ----------------------------------------------------------------------------
interface itra_in_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface itra_out_if;
	logic                           valid;
	logic                           ready;
	logic [itra_pkg::CHAR_BITS-1:0] digit_char;
	logic                           last;
	logic                           bad_radix;

	modport source (output valid, output digit_char, output last, output bad_radix,
		input ready);
	modport sink (input valid, input digit_char, input last, input bad_radix,
		output ready);
endinterface

interface itra_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [itra_pkg::RADIX_BITS-1:0] radix;

	modport source (output valid, output radix, input ready);
	modport sink (input valid, input radix, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/itra_dabble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra_dabble
// one shift-and-add-3 step of binary to bcd conversion
// ----------------------------------------------------------------------------
module itra_dabble #(
	parameter int NDIG = 10
) (
	input  wire logic [4*NDIG-1:0] bcd,
	input  wire logic              bit_in,
	output logic      [4*NDIG-1:0] bcd_next
);

	logic [4*NDIG-1:0] adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adj[4*NDIG-2:0], bit_in};

endmodule
`default_nettype wire

// ===== rtl/core/itra_digit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra_digit
// picks one digit from the working word and maps it to ascii
// ----------------------------------------------------------------------------
module itra_digit #(
	parameter int VALUE_BITS = 31,
	parameter int NDIG       = 10,
	parameter int IW         = 5
) (
	input  wire itra_pkg::radix_sel_t                 rsel,
	input  wire logic [IW-1:0]                        idx,
	input  wire logic [VALUE_BITS-1:0]                val,
	input  wire logic [4*NDIG-1:0]                    bcd,
	output logic      [3:0]                           digit,
	output logic      [itra_pkg::CHAR_BITS-1:0]       ascii
);

	logic [4*VALUE_BITS-1:0] ext_val;
	logic [4*VALUE_BITS-1:0] ext_bcd;

	assign ext_val = (4*VALUE_BITS)'(val);
	assign ext_bcd = (4*VALUE_BITS)'(bcd);

	always_comb begin
		case (rsel)
			itra_pkg::RSEL_BIN: digit = {3'b000, ext_val[int'(idx)]};
			itra_pkg::RSEL_OCT: digit = {1'b0, ext_val[3*int'(idx) +: 3]};
			itra_pkg::RSEL_HEX: digit = ext_val[4*int'(idx) +: 4];
			itra_pkg::RSEL_DEC: digit = ext_bcd[4*int'(idx) +: 4];
			default:            digit = 4'd0;
		endcase
	end

	assign ascii = itra_pkg::DIGIT_TABLE[digit];

endmodule
`default_nettype wire

// ===== rtl/core/integer_to_radix_ascii_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top
// converts a non-negative integer to lower-case ascii digits, msb first
// ----------------------------------------------------------------------------
// sequence: radix 2, 8, 16 emit straight after the request, from the top digit slot
//   down; radix 10 first runs VALUE_BITS bcd shift-add-3 steps in ST_CONV
// throughput: one character per cycle while the output is not stalled, leading zero
//   slots are skipped with no character; a new value is taken only back in ST_IDLE
// reset: arst_n clears the sequencer and output valid, radix returns to 10
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top #(
	parameter int VALUE_BITS = 31
) (
	input wire logic clk,
	input wire logic arst_n,
	itra_in_if.sink  din,
	itra_out_if.source dout,
	itra_cfg_if.sink cfg
);

	localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int ND8  = (VALUE_BITS + 2) / 3;
	localparam int ND16 = (VALUE_BITS + 3) / 4;
	localparam int IW   = $clog2(VALUE_BITS);
	localparam int CW   = $clog2(VALUE_BITS);

	itra_pkg::state_t     state_q, state_d;
	itra_pkg::radix_sel_t rsel_q, rsel_in;

	logic [itra_pkg::RADIX_BITS-1:0] radix_q;
	logic [VALUE_BITS-1:0]           val_q;
	logic [4*NDIG-1:0]               bcd_q, bcd_next;
	logic [CW-1:0]                   cnt_q;
	logic [IW-1:0]                   idx_q, idx_top;
	logic                            started_q;
	logic                            bad_in;

	logic                            ov_q;
	logic [itra_pkg::CHAR_BITS-1:0]  ochar_q;
	logic                            olast_q, obad_q;

	logic [3:0]                      digit;
	logic [itra_pkg::CHAR_BITS-1:0]  ascii;
	logic                            acc, out_free, emit_now, idx_zero;

	logic load_out, ld_last, ld_bad, idx_dec, step_en, start_set;
	logic [itra_pkg::CHAR_BITS-1:0] ld_char;

	assign din.ready  = (state_q == itra_pkg::ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign acc        = din.valid && din.ready;
	assign out_free   = !ov_q || dout.ready;
	assign idx_zero   = (idx_q == '0);
	assign emit_now   = started_q || (digit != 4'd0) || idx_zero;

	always_comb begin
		bad_in  = 1'b0;
		rsel_in = itra_pkg::RSEL_DEC;
		case (radix_q)
			itra_pkg::RADIX_BIN: rsel_in = itra_pkg::RSEL_BIN;
			itra_pkg::RADIX_OCT: rsel_in = itra_pkg::RSEL_OCT;
			itra_pkg::RADIX_DEC: rsel_in = itra_pkg::RSEL_DEC;
			itra_pkg::RADIX_HEX: rsel_in = itra_pkg::RSEL_HEX;
			default:             bad_in  = 1'b1;
		endcase
	end

	always_comb begin
		case (rsel_in)
			itra_pkg::RSEL_BIN: idx_top = IW'(VALUE_BITS - 1);
			itra_pkg::RSEL_OCT: idx_top = IW'(ND8 - 1);
			itra_pkg::RSEL_HEX: idx_top = IW'(ND16 - 1);
			default:            idx_top = IW'(NDIG - 1);
		endcase
	end

	itra_dabble #(.NDIG(NDIG)) u_dabble (
		.bcd      (bcd_q),
		.bit_in   (val_q[VALUE_BITS-1]),
		.bcd_next (bcd_next)
	);

	itra_digit #(.VALUE_BITS(VALUE_BITS), .NDIG(NDIG), .IW(IW)) u_digit (
		.rsel  (rsel_q),
		.idx   (idx_q),
		.val   (val_q),
		.bcd   (bcd_q),
		.digit (digit),
		.ascii (ascii)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			itra_pkg::ST_IDLE: begin
				if (acc) begin
					if (bad_in) begin
						state_d = itra_pkg::ST_ERR;
					end else if (rsel_in == itra_pkg::RSEL_DEC) begin
						state_d = itra_pkg::ST_CONV;
					end else begin
						state_d = itra_pkg::ST_EMIT;
					end
				end
			end
			itra_pkg::ST_CONV: begin
				if (cnt_q == CW'(VALUE_BITS - 1)) begin
					state_d = itra_pkg::ST_EMIT;
				end
			end
			itra_pkg::ST_EMIT: begin
				if (out_free && emit_now && idx_zero) begin
					state_d = itra_pkg::ST_IDLE;
				end
			end
			itra_pkg::ST_ERR: begin
				if (out_free) begin
					state_d = itra_pkg::ST_IDLE;
				end
			end
			default: state_d = itra_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		load_out  = 1'b0;
		ld_char   = itra_pkg::ERR_CHAR;
		ld_last   = 1'b0;
		ld_bad    = 1'b0;
		idx_dec   = 1'b0;
		step_en   = 1'b0;
		start_set = 1'b0;
		case (state_q)
			itra_pkg::ST_CONV: begin
				step_en = 1'b1;
			end
			itra_pkg::ST_EMIT: begin
				if (out_free) begin
					if (emit_now) begin
						load_out  = 1'b1;
						ld_char   = ascii;
						ld_last   = idx_zero;
						start_set = 1'b1;
					end
					idx_dec = !idx_zero;
				end
			end
			itra_pkg::ST_ERR: begin
				if (out_free) begin
					load_out = 1'b1;
					ld_last  = 1'b1;
					ld_bad   = 1'b1;
				end
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= itra_pkg::ST_IDLE;
			radix_q   <= itra_pkg::RADIX_RESET;
			ov_q      <= 1'b0;
			started_q <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			rsel_q    <= itra_pkg::RSEL_DEC;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				radix_q <= cfg.radix;
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
			if (acc) begin
				started_q <= 1'b0;
				cnt_q     <= '0;
				idx_q     <= (rsel_in == itra_pkg::RSEL_DEC) ? IW'(NDIG - 1) : idx_top;
				rsel_q    <= rsel_in;
			end else begin
				if (start_set) begin
					started_q <= 1'b1;
				end
				if (step_en) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (idx_dec) begin
					idx_q <= idx_q - IW'(1);
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			val_q <= din.value;
			bcd_q <= '0;
		end else if (step_en) begin
			val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
		if (load_out) begin
			ochar_q <= ld_char;
			olast_q <= ld_last;
			obad_q  <= ld_bad;
		end
	end

	assign dout.valid      = ov_q;
	assign dout.digit_char = ochar_q;
	assign dout.last       = olast_q;
	assign dout.bad_radix  = obad_q;

endmodule
`default_nettype wire

// ===== rtl/core/itra_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra_checker
// port level checks for the radix to ascii converter
// ----------------------------------------------------------------------------
module itra_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_char,
	input wire logic       out_last,
	input wire logic       out_bad
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
			&& $stable(out_bad))
		else $error("result changed while stalled");

	// error result is a single null character
	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad |-> out_last && out_char == 8'h00)
		else $error("bad radix result malformed");

	// good results are lower-case digits
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_bad |->
			(out_char >= 8'h30 && out_char <= 8'h39) ||
			(out_char >= 8'h61 && out_char <= 8'h66))
		else $error("digit character out of range");

	// busy after a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new request taken during conversion");

	// a run is still in progress until its last character
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |-> !in_ready)
		else $error("idle before last character");

endmodule

bind integer_to_radix_ascii_top itra_checker u_itra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_char  (dout.digit_char),
	.out_last  (dout.last),
	.out_bad   (dout.bad_radix)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the radix to ascii converter against a behavioural digit predictor:
// each accepted value request is expanded into its expected characters, and
// every character request leaving the block is compared with the oldest one
// ----------------------------------------------------------------------------
module testbench;

	localparam int VALUE_BITS     = 31;
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = VALUE_BITS + 16;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	localparam int MAX_REPORTS    = 10;

	localparam logic [itra_pkg::CHAR_BITS-1:0] ASCII_ZERO    = 8'h30;
	localparam logic [itra_pkg::CHAR_BITS-1:0] ASCII_LOWER_A = 8'h61;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [itra_pkg::RADIX_BITS-1:0] radix_t;

	typedef struct packed {
		logic [itra_pkg::CHAR_BITS-1:0] digit_char;
		logic                           last;
		logic                           bad_radix;
	} char_res_t;

	logic clk;
	logic arst_n;

	itra_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
	itra_out_if out_ch ();
	itra_cfg_if cfg_ch ();

	integer_to_radix_ascii_top #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch),
		.cfg(cfg_ch)
	);

	char_res_t expected_chars [$];
	radix_t    cur_radix;
	logic      in_burst;
	logic      out_burst;
	int        n_fail;
	int        n_values_sent;
	int        n_chars_checked;
	int        n_bad_conversions;
	int        n_radix_writes;

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	initial begin
		#(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
		$display("timeout with %0d characters outstanding", expected_chars.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic radix_supported(input radix_t r);
		return r inside {itra_pkg::RADIX_BIN, itra_pkg::RADIX_OCT, itra_pkg::RADIX_DEC,
			itra_pkg::RADIX_HEX};
	endfunction

	// expected characters for one value at the current radix, msd first
	function automatic void push_expected_chars(input value_t v);
		value_t     n;
		logic [3:0] digs [VALUE_BITS];
		int         cnt;
		char_res_t  c;
		n = v;
		cnt = 0;
		if (!radix_supported(cur_radix)) begin
			c.digit_char = itra_pkg::ERR_CHAR;
			c.last = 1'b1;
			c.bad_radix = 1'b1;
			expected_chars.push_back(c);
			n_bad_conversions++;
			return;
		end
		if (n == '0) begin
			digs[0] = 4'd0;
			cnt = 1;
		end
		while (n != '0) begin
			digs[cnt] = 4'(n % cur_radix);
			n = n / cur_radix;
			cnt++;
		end
		for (int k = cnt - 1; k >= 0; k--) begin
			if (digs[k] < 4'd10)
				c.digit_char = ASCII_ZERO + 8'(digs[k]);
			else
				c.digit_char = ASCII_LOWER_A + 8'(digs[k]) - 8'd10;
			c.last = (k == 0);
			c.bad_radix = 1'b0;
			expected_chars.push_back(c);
		end
	endfunction

	task automatic report_fail(input string what, input char_res_t want, input char_res_t got);
		n_fail++;
		if (n_fail <= MAX_REPORTS)
			$display("%0t: %s: expected char %h last %b bad %b, got char %h last %b bad %b",
				$time, what, want.digit_char, want.last, want.bad_radix,
				got.digit_char, got.last, got.bad_radix);
	endtask

	task automatic check_char();
		char_res_t got;
		char_res_t want;
		got = {out_ch.digit_char, out_ch.last, out_ch.bad_radix};
		n_chars_checked++;
		if (expected_chars.size() == 0) begin
			report_fail("character with nothing expected", '0, got);
			return;
		end
		want = expected_chars.pop_front();
		if (got.digit_char !== want.digit_char || got.last !== want.last
				|| got.bad_radix !== want.bad_radix)
			report_fail("character mismatch", want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			check_char();
	end

	// output back-pressure: mostly ready, short stalls, the odd long one
	initial begin
		int hold;
		int pick;
		hold = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_burst) begin
				out_ch.ready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					out_ch.ready <= 1'b1;
					hold = $urandom_range(0, 20);
				end else if (pick < 93) begin
					out_ch.ready <= 1'b0;
					hold = $urandom_range(0, 2);
				end else begin
					out_ch.ready <= 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int pick;
		if (in_burst)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic value_t random_value();
		int     width;
		value_t v;
		width = $urandom_range(0, VALUE_BITS);
		v = VALUE_BITS'({$urandom, $urandom});
		return v & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - width));
	endfunction

	// valid is left high after the request so back-to-back values need no toggle
	task automatic send_value(input value_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		push_expected_chars(v);
		n_values_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input radix_t r);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.radix <= r;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cur_radix = r;
		n_radix_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// decimal is the radix left by reset
	task automatic test_reset_radix();
		send_value('0);
		send_value(value_t'(1));
		send_value(value_t'(9));
		send_value(value_t'(10));
		send_value(value_t'(99));
		send_value('1);
	endtask

	task automatic test_each_radix();
		radix_t radices [3];
		radices = '{itra_pkg::RADIX_BIN, itra_pkg::RADIX_OCT, itra_pkg::RADIX_HEX};
		foreach (radices[i]) begin
			write_radix(radices[i]);
			send_value('0);
			send_value('1);
			send_value(value_t'(radices[i] - 1));
			send_value(value_t'(radices[i]));
		end
	endtask

	// unsupported radix values at both ends of the register range
	task automatic test_bad_radix();
		write_radix('0);
		send_value(random_value());
		write_radix('1);
		send_value('1);
	endtask

	task automatic test_pause_until_drained();
		write_radix(itra_pkg::RADIX_DEC);
		repeat (20) send_value(random_value());
		wait_drained();
		repeat (20) send_value(random_value());
	endtask

	task automatic test_random_radices();
		radix_t good [4];
		radix_t r;
		good = '{itra_pkg::RADIX_BIN, itra_pkg::RADIX_OCT, itra_pkg::RADIX_DEC,
			itra_pkg::RADIX_HEX};
		for (int ph = 0; ph < 12; ph++) begin
			if ($urandom_range(0, 4) == 0)
				r = radix_t'($urandom_range(0, 31));
			else
				r = good[$urandom_range(0, 3)];
			write_radix(r);
			in_burst = ($urandom_range(0, 3) == 0);
			out_burst = ($urandom_range(0, 3) == 0);
			repeat (25) send_value(random_value());
			in_burst = 1'b0;
			out_burst = 1'b0;
		end
	endtask

	initial begin
		cur_radix = itra_pkg::RADIX_RESET;
		in_burst = 1'b0;
		out_burst = 1'b0;
		n_fail = 0;
		n_values_sent = 0;
		n_chars_checked = 0;
		n_bad_conversions = 0;
		n_radix_writes = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.radix <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_radix();
		test_each_radix();
		test_bad_radix();
		test_pause_until_drained();
		test_random_radices();

		wait_drained();
		if (expected_chars.size() != 0)
			n_fail++;
		$display("run covered %0d values over %0d radix writes, %0d characters checked",
			n_values_sent, n_radix_writes, n_chars_checked);
		$display("%0d conversions hit an unsupported radix, %0d failures",
			n_bad_conversions, n_fail);
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
